/* hw/rtl/spvf_pkg.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter package
// Shared sizes, register codes and the velocity store control bundle.
// ----------------------------------------------------------------------------
package spvf_pkg;

   localparam int NUM_POINTS = 360;
   localparam int TIME_INDEX = 69;
   localparam int IDX_W      = $clog2(NUM_POINTS);

   localparam int DIVIDEND_W = 36;
   localparam int DIVISOR_W  = 21;
   localparam int CNT_W      = 10;

   localparam logic [19:0] VEL_SCALE = 20'd1000000;

   localparam logic [1:0] REG_RANGE_LIMIT   = 2'd0;
   localparam logic [1:0] REG_SPEED_LIMIT   = 2'd1;
   localparam logic [1:0] REG_OUTLIER_SPEED = 2'd2;
   localparam logic [1:0] REG_OUTLIER_LIMIT = 2'd3;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [31:0]      wr_data;
      logic             rd_en;
      logic [8:0]       rd_addr;
      logic             zero_set;
      logic             zero_val;
   } vel_ctl_type;

endpackage

/* hw/rtl/spvf_ifs.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter channels
// Request and response channels with valid and ready.
// ----------------------------------------------------------------------------
interface spvf_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic [19:0]        point_time;
   logic [8:0]         read_index;

   modport source(output valid, req_type, point_x, point_y, point_time, read_index,
                  input ready);
   modport sink(input valid, req_type, point_x, point_y, point_time, read_index,
                output ready);
endinterface

interface spvf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic               scan_done;
   logic [8:0]         outlier_total;

   modport source(output valid, vel_x, vel_y, scan_done, outlier_total, input ready);
   modport sink(input valid, vel_x, vel_y, scan_done, outlier_total, output ready);
endinterface

/* hw/rtl/spvf_div.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spvf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [spvf_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [spvf_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic [spvf_pkg::DIVIDEND_W-1:0] quotient
);
   import spvf_pkg::*;

   logic                  busy_ff;
   logic [5:0]            cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge       = shifted >= {1'b0, divisor};
   assign diff     = shifted - {1'b0, divisor};
   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 6'(DIVIDEND_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
      end
   end

endmodule

/* hw/rtl/spvf_vel_mem.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter velocity store
// Velocity memory with registered read, range check and a whole-scan zero flag.
// ----------------------------------------------------------------------------
module spvf_vel_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  spvf_pkg::vel_ctl_type ctl,
   output logic [31:0]           rd_data
);
   import spvf_pkg::*;

   logic [31:0] mem [NUM_POINTS];
   logic [31:0] data_ff;
   logic        hit_ff;
   logic        zero_all_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         data_ff <= mem[ctl.rd_addr[IDX_W-1:0]];
         hit_ff  <= {1'b0, ctl.rd_addr} < 10'(NUM_POINTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_all_ff <= 1'b1;
      end else if (ctl.zero_set) begin
         zero_all_ff <= ctl.zero_val;
      end
   end

   assign rd_data = (hit_ff && !zero_all_ff) ? data_ff : 32'd0;

endmodule

/* hw/rtl/scan_point_velocity_filter_unit.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter unit
// Per-point history with dropout fill and an end-of-scan velocity pass.
// ----------------------------------------------------------------------------
// A read goes from the output state through the response register; a store runs
// the dropout search and the history write first. The last store of a scan adds
// a velocity pass over all points with two serial dividers; one request is in
// work at a time. After reset a clearing pass zeroes the history memory, during
// which no request is taken. Reset is synchronous and active high.
module scan_point_velocity_filter_unit (
   input  logic        clock,
   input  logic        reset,
   spvf_req_if.sink    req_chan,
   spvf_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   import spvf_pkg::*;

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_NORM = 4'd2;
   localparam logic [3:0] ST_SWR  = 4'd3;
   localparam logic [3:0] ST_PRD  = 4'd4;
   localparam logic [3:0] ST_PLD  = 4'd5;
   localparam logic [3:0] ST_PMUL = 4'd6;
   localparam logic [3:0] ST_PDST = 4'd7;
   localparam logic [3:0] ST_PDIV = 4'd8;
   localparam logic [3:0] ST_PSQ  = 4'd9;
   localparam logic [3:0] ST_PCHK = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);
   localparam logic [8:0]       TIME_IDX = 9'(TIME_INDEX);

   function automatic logic [15:0] sat16(input logic [16:0] mag, input logic neg);
      logic [15:0] res;
      if (!neg) begin
         res = (mag > 17'd32767) ? 16'h7fff : mag[15:0];
      end else begin
         res = (mag >= 17'd32768) ? 16'h8000 : (~mag[15:0] + 16'd1);
      end
      return res;
   endfunction

   logic [3:0]  state_ff, state_in;

   logic [14:0] range_ff, speed_ff, ospeed_ff;
   logic [9:0]  olimit_ff;
   logic [29:0] r2_ff, sl2_ff, ol2_ff;

   logic [127:0]     hist_mem [NUM_POINTS];
   logic [127:0]     hist_rd_ff;
   logic             hist_re;
   logic [IDX_W-1:0] hist_raddr;
   logic             hist_we;
   logic [IDX_W-1:0] hist_waddr;
   logic [127:0]     hist_wdata;

   logic [IDX_W-1:0] clr_ff;
   logic [IDX_W-1:0] counter_ff;
   logic [IDX_W-1:0] pi_ff;
   logic [1:0]       k_ff;
   logic             found_ff;
   logic [31:0]      sel_ff;
   logic             mode_rd_ff;
   logic [31:0]      raw_ff;
   logic [19:0]      ptime_ff;
   logic [19:0]      now_ff, before_ff;
   logic [CNT_W-1:0] count_ff;
   logic [8:0]       ototal_ff;
   logic             done_ff;

   logic [16:0]      absx_ff, absy_ff;
   logic             negx_ff, negy_ff;
   logic [DIVIDEND_W-1:0] numx_ff, numy_ff;
   logic [16:0]      cmx_ff, cmy_ff;
   logic [33:0]      sqx_ff, sqy_ff;

   logic             rsp_valid_ff;
   logic [15:0]      rsp_x_ff, rsp_y_ff;
   logic             rsp_done_ff;
   logic [8:0]       rsp_tot_ff;

   logic             accept;
   logic [31:0]      cand;
   logic [32:0]      cand_norm;
   logic [31:0]      new_cur;
   logic [16:0]      dx, dy;
   logic [20:0]      div_sum;
   logic             div_zero;
   logic             div_start;
   logic             busy_x, busy_y;
   logic [DIVIDEND_W-1:0] qx, qy, qxs, qys;
   logic [16:0]      cmx, cmy;
   logic [34:0]      s2;
   logic             is_outl, is_kill;
   logic [CNT_W-1:0] count_next;
   logic [31:0]      vel_word;
   logic             out_free;
   vel_ctl_type      vctl;
   logic [31:0]      vel_rd;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign div_sum  = {1'b0, now_ff} + {1'b0, before_ff};
   assign div_zero = (div_sum == 21'd0);

   // Configuration registers and squared limits.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= 15'd0;
         speed_ff  <= 15'd1280;
         ospeed_ff <= 15'd896;
         olimit_ff <= 10'd150;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANGE_LIMIT:   range_ff  <= csr_wdata;
            REG_SPEED_LIMIT:   speed_ff  <= csr_wdata;
            REG_OUTLIER_SPEED: ospeed_ff <= csr_wdata;
            REG_OUTLIER_LIMIT: olimit_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff  <= range_ff * range_ff;
      sl2_ff <= speed_ff * speed_ff;
      ol2_ff <= ospeed_ff * ospeed_ff;
   end

   // Dropout candidates: raw, then previous, older and oldest history.
   always_comb begin
      case (k_ff)
         2'd0:    cand = raw_ff;
         2'd1:    cand = hist_rd_ff[31:0];
         2'd2:    cand = hist_rd_ff[63:32];
         default: cand = hist_rd_ff[95:64];
      endcase
   end

   assign cand_norm = 33'($signed(cand[31:16]) * $signed(cand[31:16]))
                    + 33'($signed(cand[15:0]) * $signed(cand[15:0]));
   assign new_cur   = found_ff ? sel_ff : raw_ff;

   assign hist_re    = (state_ff == ST_PRD) || (accept && !req_chan.req_type);
   assign hist_raddr = (state_ff == ST_PRD) ? pi_ff : counter_ff;
   assign hist_we    = (state_ff == ST_CLR) || (state_ff == ST_SWR);
   assign hist_waddr = (state_ff == ST_CLR) ? clr_ff : counter_ff;
   assign hist_wdata = (state_ff == ST_CLR) ? 128'd0 :
                       {hist_rd_ff[95:0], new_cur};

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   // Velocity pass arithmetic.
   assign dx = {hist_rd_ff[31], hist_rd_ff[31:16]} - {hist_rd_ff[63], hist_rd_ff[63:48]};
   assign dy = {hist_rd_ff[15], hist_rd_ff[15:0]} - {hist_rd_ff[47], hist_rd_ff[47:32]};
   assign div_start = (state_ff == ST_PDST) && !div_zero;

   spvf_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(numx_ff),
      .divisor(div_sum), .busy(busy_x), .quotient(qx)
   );

   spvf_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(numy_ff),
      .divisor(div_sum), .busy(busy_y), .quotient(qy)
   );

   assign qxs = div_zero ? '0 : qx;
   assign qys = div_zero ? '0 : qy;
   assign cmx = (qxs > DIVIDEND_W'(65536)) ? 17'd65536 : qxs[16:0];
   assign cmy = (qys > DIVIDEND_W'(65536)) ? 17'd65536 : qys[16:0];

   assign s2         = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign is_outl    = s2 > {5'd0, ol2_ff};
   assign is_kill    = s2 > {5'd0, sl2_ff};
   assign count_next = count_ff + CNT_W'(is_outl);
   assign vel_word   = is_kill ? 32'd0 : {sat16(cmx_ff, negx_ff), sat16(cmy_ff, negy_ff)};

   always_comb begin
      vctl          = '0;
      vctl.wr_en    = (state_ff == ST_PCHK);
      vctl.wr_addr  = pi_ff;
      vctl.wr_data  = vel_word;
      vctl.rd_en    = accept && req_chan.req_type;
      vctl.rd_addr  = req_chan.read_index;
      vctl.zero_set = (state_ff == ST_PCHK) && (pi_ff == LAST_IDX);
      vctl.zero_val = count_next >= olimit_ff;
   end

   spvf_vel_mem u_vel_mem (
      .clock(clock), .reset(reset), .ctl(vctl), .rd_data(vel_rd)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR:  if (clr_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = req_chan.req_type ? ST_OUT : ST_NORM;
         ST_NORM: if (k_ff == 2'd3) state_in = ST_SWR;
         ST_SWR:  state_in = (counter_ff == LAST_IDX) ? ST_PRD : ST_OUT;
         ST_PRD:  state_in = ST_PLD;
         ST_PLD:  state_in = ST_PMUL;
         ST_PMUL: state_in = ST_PDST;
         ST_PDST: state_in = ST_PDIV;
         ST_PDIV: if (!busy_x && !busy_y) state_in = ST_PSQ;
         ST_PSQ:  state_in = ST_PCHK;
         ST_PCHK: state_in = (pi_ff == LAST_IDX) ? ST_OUT : ST_PRD;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         clr_ff     <= '0;
         counter_ff <= '0;
         now_ff     <= '0;
         before_ff  <= '0;
         ototal_ff  <= '0;
         count_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLR) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (state_ff == ST_SWR) begin
            if ({{(9-IDX_W){1'b0}}, counter_ff} == TIME_IDX) begin
               now_ff <= ptime_ff;
            end
            counter_ff <= (counter_ff == LAST_IDX) ? '0 : counter_ff + IDX_W'(1);
            count_ff   <= '0;
         end
         if (state_ff == ST_PCHK) begin
            count_ff <= count_next;
            if (pi_ff == LAST_IDX) begin
               ototal_ff <= (count_next > CNT_W'(511)) ? 9'd511 : count_next[8:0];
               before_ff <= now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_rd_ff <= req_chan.req_type;
         raw_ff     <= {req_chan.point_x, req_chan.point_y};
         ptime_ff   <= req_chan.point_time;
         k_ff       <= 2'd0;
         found_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end
      if (state_ff == ST_NORM) begin
         k_ff <= k_ff + 2'd1;
         if (!found_ff && (cand_norm != {3'd0, r2_ff})) begin
            found_ff <= 1'b1;
            sel_ff   <= cand;
         end
      end
      if (state_ff == ST_SWR) begin
         pi_ff <= '0;
      end
      if (state_ff == ST_PLD) begin
         negx_ff <= dx[16];
         negy_ff <= dy[16];
         absx_ff <= dx[16] ? (~dx + 17'd1) : dx;
         absy_ff <= dy[16] ? (~dy + 17'd1) : dy;
      end
      if (state_ff == ST_PMUL) begin
         numx_ff <= DIVIDEND_W'(absx_ff * VEL_SCALE);
         numy_ff <= DIVIDEND_W'(absy_ff * VEL_SCALE);
      end
      if (state_ff == ST_PSQ) begin
         cmx_ff <= cmx;
         cmy_ff <= cmy;
         sqx_ff <= cmx * cmx;
         sqy_ff <= cmy * cmy;
      end
      if (state_ff == ST_PCHK) begin
         pi_ff <= pi_ff + IDX_W'(1);
         if (pi_ff == LAST_IDX) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_x_ff    <= mode_rd_ff ? vel_rd[31:16] : 16'd0;
         rsp_y_ff    <= mode_rd_ff ? vel_rd[15:0] : 16'd0;
         rsp_done_ff <= done_ff;
         rsp_tot_ff  <= ototal_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.vel_x         = rsp_x_ff;
   assign rsp_chan.vel_y         = rsp_y_ff;
   assign rsp_chan.scan_done     = rsp_done_ff;
   assign rsp_chan.outlier_total = rsp_tot_ff;

endmodule

/* hw/rtl/spvf_checker.sv */
// ----------------------------------------------------------------------------
// Scan point velocity filter checker
// Port-level properties of the filter unit, bound to the top level.
// ----------------------------------------------------------------------------
module spvf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] vel_x,
   input logic [15:0] vel_y,
   input logic        scan_done
);

   // A response held back by the sink stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // The history memory is cleared before any request is taken.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the clearing pass");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   // A response that closes a scan comes from a store and carries no velocity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && scan_done |-> vel_x == 16'd0 && vel_y == 16'd0)
      else $error("scan completion carries a velocity");

endmodule

bind scan_point_velocity_filter_unit spvf_checker u_spvf_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .vel_x(rsp_chan.vel_x),
   .vel_y(rsp_chan.vel_y),
   .scan_done(rsp_chan.scan_done)
);
